// ===== rtl/core/mtmp_pkg.sv =====
// Shared types and constants for the mixer TCP MIDI packet parser.
`timescale 1ns / 1ps
`default_nettype none

package mtmp_pkg;

   localparam logic [7:0]  DELIM_BYTE    = 8'h00;

   localparam logic [15:0] TYPE_INCOMING = 16'd19789;
   localparam logic [15:0] TYPE_OUTGOING = 16'd19777;
   localparam logic [15:0] TYPE_SYSEX    = 16'd21331;

   localparam logic [2:0] KIND_IN      = 3'd0;
   localparam logic [2:0] KIND_OUT     = 3'd1;
   localparam logic [2:0] KIND_SYSEX   = 3'd2;
   localparam logic [2:0] KIND_UNKNOWN = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_BAD_HEADER = 3'd1;
   localparam logic [2:0] STATUS_NO_DELIM   = 3'd2;
   localparam logic [2:0] STATUS_SYSEX_LEN  = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd4;

   localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
   localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
   localparam logic [1:0] REG_MARKER       = 2'd2;

   typedef enum logic [3:0] {
      PH_HUNT   = 4'd0,
      PH_MAGIC2 = 4'd1,
      PH_DELIM1 = 4'd2,
      PH_MARKER = 4'd3,
      PH_LENGTH = 4'd4,
      PH_DELIM2 = 4'd5,
      PH_BODY   = 4'd6
   } phase_type;

   // One queue entry: an optional data result followed by an optional packet end.
   typedef struct packed {
      logic       has_data;
      logic [2:0] data_kind;
      logic [7:0] data_dev;
      logic [7:0] data_a;
      logic [7:0] data_b;
      logic [7:0] data_c;
      logic       has_end;
      logic [2:0] end_status;
      logic [7:0] end_dev;
   } entry_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] dev;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [2:0] status;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/mixer_tcp_midi_packet_parser_core.sv =====
// Top level of the mixer TCP MIDI packet parser.
`timescale 1ns / 1ps
`default_nettype none

// Parses a byte stream of mixer link packets (six-byte header, then a typed
// body) and turns it into MIDI, sysex and pass-through results, each packet
// closed by an end result carrying its status. One byte is taken per clock
// while the entry queue has room: the front parser updates its state on every
// accepted byte, so req_tready stays high whenever the entry queue has room.
// Parsed entries wait in a QUEUE_DEPTH-deep queue; the back end emits one
// result per cycle while rsp_tready does not stall it, through a registered
// output, so a byte that yields both a data result and a packet end gives
// two results in turn. An accepted byte's results pass through the queue
// store and then the output register. The three match registers are written
// over the csr_ port (always ready) and should only be changed while the parser is idle.
module mixer_tcp_midi_packet_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [7:0] device_code, [15:8] byte_a,
                                          // [23:16] byte_b, [31:24] byte_c,
                                          // [34:32] status, [39:35] zero
   output logic [2:0]       rsp_tuser,    // [2:0] event_kind
   output logic             rsp_tlast,    // last: set on the packet end
   // register writes: 0 magic_first, 1 magic_second, 2 marker_value
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import mtmp_pkg::*;

   entry_type  front_entry;
   entry_type  head_entry;
   logic       front_push;
   logic       queue_empty, queue_full;
   logic       back_pop;
   logic       accept;
   result_type result;

   // take a byte whenever the queue can absorb what it produces
   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   mtmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .data_byte (req_tdata),
      .entry     (front_entry),
      .push      (front_push)
   );

   mtmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (back_pop),
      .head       (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   mtmp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_entry),
      .empty      (queue_empty),
      .pop        (back_pop),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (result)
   );

   // pack the result, lowest field first, padded to whole bytes
   assign rsp_tdata = {5'b00000, result.status, result.c, result.b, result.a, result.dev};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule

`default_nettype wire

// ===== rtl/core/mtmp_front.sv =====
// Front end: configuration registers, packet header and body parsing.
`timescale 1ns / 1ps
`default_nettype none

module mtmp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_data,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   output mtmp_pkg::entry_type     entry,
   output logic                    push
);
   import mtmp_pkg::*;

   logic [7:0]  magic_first_ff, magic_second_ff, marker_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] type_ff, type_in;
   logic [7:0]  dev_ff, dev_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [7:0]  sx_exp_ff, sx_exp_in;
   logic [7:0]  sx_seen_ff, sx_seen_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  sub_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= 8'd85;
         magic_second_ff <= 8'd67;
         marker_ff       <= 8'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MAGIC_FIRST:  magic_first_ff  <= csr_data;
            REG_MAGIC_SECOND: magic_second_ff <= csr_data;
            REG_MARKER:       marker_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         pos_ff      <= '0;
         len_ff      <= '0;
         type_ff     <= '0;
         dev_ff      <= '0;
         held_ff     <= '0;
         held_cnt_ff <= '0;
         sx_exp_ff   <= '0;
         sx_seen_ff  <= '0;
         err_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         type_ff     <= type_in;
         dev_ff      <= dev_in;
         held_ff     <= held_in;
         held_cnt_ff <= held_cnt_in;
         sx_exp_ff   <= sx_exp_in;
         sx_seen_ff  <= sx_seen_in;
         err_ff      <= err_in;
      end
   end

   assign sub_pos = pos_ff - 8'd4;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      type_in     = type_ff;
      dev_in      = dev_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      sx_exp_in   = sx_exp_ff;
      sx_seen_in  = sx_seen_ff;
      err_in      = err_ff;
      entry       = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (data_byte == magic_first_ff) phase_in = PH_MAGIC2;
            end
            PH_MAGIC2: begin
               if (data_byte != magic_second_ff) begin
                  entry.has_end    = 1'b1;
                  entry.end_status = STATUS_BAD_HEADER;
                  phase_in = (data_byte == magic_first_ff) ? PH_MAGIC2 : PH_HUNT;
               end else begin
                  phase_in = PH_DELIM1;
               end
            end
            PH_DELIM1: begin
               if (data_byte != DELIM_BYTE) begin
                  entry.has_end    = 1'b1;
                  entry.end_status = STATUS_NO_DELIM;
                  phase_in = (data_byte == magic_first_ff) ? PH_MAGIC2 : PH_HUNT;
               end else begin
                  phase_in = PH_MARKER;
               end
            end
            PH_MARKER: begin
               if (data_byte != marker_ff) begin
                  entry.has_end    = 1'b1;
                  entry.end_status = STATUS_BAD_HEADER;
                  phase_in = (data_byte == magic_first_ff) ? PH_MAGIC2 : PH_HUNT;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               len_in   = data_byte;
               phase_in = PH_DELIM2;
            end
            PH_DELIM2: begin
               if (data_byte != DELIM_BYTE) begin
                  entry.has_end    = 1'b1;
                  entry.end_status = STATUS_NO_DELIM;
                  phase_in = (data_byte == magic_first_ff) ? PH_MAGIC2 : PH_HUNT;
               end else begin
                  // open a fresh body
                  pos_in      = '0;
                  type_in     = '0;
                  dev_in      = '0;
                  held_in     = '0;
                  held_cnt_in = '0;
                  sx_exp_in   = '0;
                  sx_seen_in  = '0;
                  err_in      = STATUS_OK;
                  if (len_ff == 8'd0) begin
                     entry.has_end    = 1'b1;
                     entry.end_status = STATUS_TRUNCATED;
                     phase_in = PH_HUNT;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (err_ff == STATUS_OK) begin
                  if (pos_ff == 8'd0) begin
                     type_in = {data_byte, 8'h00};
                  end else if (pos_ff == 8'd1) begin
                     type_in = {type_ff[15:8], data_byte};
                  end else if (pos_ff == 8'd2 || pos_ff == 8'd3) begin
                     if (data_byte != DELIM_BYTE) err_in = STATUS_NO_DELIM;
                  end else if (type_ff == TYPE_INCOMING) begin
                     if (sub_pos == 8'd0) begin
                        dev_in = data_byte;
                     end else if (sub_pos == 8'd1) begin
                        if (data_byte != DELIM_BYTE) err_in = STATUS_NO_DELIM;
                     end else begin
                        // emit the byte held back, hold this one
                        if (held_cnt_ff != 2'd0) begin
                           entry.has_data  = 1'b1;
                           entry.data_kind = KIND_IN;
                           entry.data_dev  = dev_ff;
                           entry.data_a    = held_ff[7:0];
                        end
                        held_in     = {8'h00, data_byte};
                        held_cnt_in = 2'd1;
                     end
                  end else if (type_ff == TYPE_OUTGOING) begin
                     if (sub_pos == 8'd0) begin
                        dev_in = data_byte;
                     end else if (sub_pos == 8'd1) begin
                        if (data_byte != DELIM_BYTE) err_in = STATUS_NO_DELIM;
                     end else if (sub_pos >= 8'd3) begin
                        if (held_cnt_ff >= 2'd2) begin
                           entry.has_data  = 1'b1;
                           entry.data_kind = KIND_OUT;
                           entry.data_dev  = dev_ff;
                           entry.data_a    = held_ff[15:8];
                           entry.data_b    = held_ff[7:0];
                           entry.data_c    = data_byte;
                           held_in     = '0;
                           held_cnt_in = '0;
                        end else begin
                           held_in     = {held_ff[7:0], data_byte};
                           held_cnt_in = held_cnt_ff + 2'd1;
                        end
                     end
                  end else if (type_ff == TYPE_SYSEX) begin
                     if (sub_pos == 8'd0) begin
                        dev_in = data_byte;
                     end else if (sub_pos == 8'd1 || sub_pos == 8'd3) begin
                        if (data_byte != DELIM_BYTE) err_in = STATUS_NO_DELIM;
                     end else if (sub_pos == 8'd2) begin
                        sx_exp_in = data_byte;
                     end else begin
                        entry.has_data  = 1'b1;
                        entry.data_kind = KIND_SYSEX;
                        entry.data_dev  = dev_ff;
                        entry.data_a    = data_byte;
                        sx_seen_in = sx_seen_ff + 8'd1;
                     end
                  end else begin
                     entry.has_data  = 1'b1;
                     entry.data_kind = KIND_UNKNOWN;
                     entry.data_a    = data_byte;
                  end
               end

               pos_in = pos_ff + 8'd1;
               if (pos_in == len_ff) begin
                  entry.has_end = 1'b1;
                  entry.end_dev = dev_in;
                  priority if (err_in != STATUS_OK) begin
                     entry.end_status = err_in;
                  end else if (len_ff < 8'd4) begin
                     entry.end_status = STATUS_TRUNCATED;
                  end else if (type_in == TYPE_INCOMING && held_cnt_in == 2'd0) begin
                     entry.end_status = STATUS_TRUNCATED;
                  end else if (type_in == TYPE_SYSEX && sx_seen_in != sx_exp_in) begin
                     entry.end_status = STATUS_SYSEX_LEN;
                  end else begin
                     entry.end_status = STATUS_OK;
                  end
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   assign push = entry.has_data | entry.has_end;

endmodule

`default_nettype wire

// ===== rtl/core/mtmp_queue.sv =====
// Short queue of parsed entries between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mtmp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  mtmp_pkg::entry_type     push_entry,
   input  wire logic               pop,
   output mtmp_pkg::entry_type     head,
   output logic                    empty,
   output logic                    full
);
   import mtmp_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   entry_type             store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  do_push, do_pop;

   assign empty   = (count_ff == CountWidth'(0));
   assign full    = (count_ff == CountWidth'(DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mtmp_back.sv =====
// Back end: split queue entries into results and drive the output register.
`timescale 1ns / 1ps
`default_nettype none

module mtmp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  mtmp_pkg::entry_type     head,
   input  wire logic               empty,
   output logic                    pop,
   input  wire logic               out_ready,
   output logic                    out_valid,
   output mtmp_pkg::result_type    out_result
);
   import mtmp_pkg::*;

   logic       valid_ff, valid_in;
   logic       data_done_ff, data_done_in;
   result_type result_ff, result_in;
   logic       load;

   assign load = ~valid_ff | out_ready;

   always_comb begin
      valid_in     = valid_ff;
      data_done_in = data_done_ff;
      result_in    = result_ff;
      pop          = 1'b0;
      if (load) begin
         valid_in = 1'b0;
         if (!empty) begin
            valid_in = 1'b1;
            if (head.has_data && !data_done_ff) begin
               result_in.kind   = head.data_kind;
               result_in.dev    = head.data_dev;
               result_in.a      = head.data_a;
               result_in.b      = head.data_b;
               result_in.c      = head.data_c;
               result_in.status = STATUS_OK;
               result_in.last   = 1'b0;
               if (head.has_end) data_done_in = 1'b1;
               else pop = 1'b1;
            end else begin
               result_in.kind   = KIND_END;
               result_in.dev    = head.end_dev;
               result_in.a      = '0;
               result_in.b      = '0;
               result_in.c      = '0;
               result_in.status = head.end_status;
               result_in.last   = 1'b1;
               data_done_in     = 1'b0;
               pop              = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         data_done_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         data_done_ff <= data_done_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire
